>>> src/u8dec_pkg.sv
// u8dec_pkg: shared widths, header masks and result status codes for the
// UTF-8 stream decoder. No dependencies.
`default_nettype none

package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned PEND_W = 2;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THR  = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_NO_CONT  = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> src/u8dec_if.sv
// u8dec_byte_if / u8dec_char_if: valid/ready channels carrying raw bytes in
// and decoded characters out. Depends on u8dec_pkg.
`default_nettype none

interface u8dec_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u8dec_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8dec_char_if;
    logic                          valid;
    logic                          ready;
    logic [u8dec_pkg::CP_W-1:0]    code_point;
    logic [u8dec_pkg::LEN_W-1:0]   seq_bytes;
    u8dec_pkg::t_status            status;

    modport source (output valid, output code_point, output seq_bytes, output status,
                    input ready);
    modport sink   (input valid, input code_point, input seq_bytes, input status,
                    output ready);
endinterface

`default_nettype wire

>>> src/utf8_stream_decoder_unit.sv
// utf8_stream_decoder_unit: top level, byte register, sequence state, decode
// logic and result register. Depends on u8dec_pkg and u8dec_if.sv.
//
//   channel   dir  interface        payload
//   i_byte    in   u8dec_byte_if    in_byte
//   o_char    out  u8dec_char_if    code_point, seq_bytes, status
//
// One byte per clock sustained while the output is not stalled. Each byte
// goes from the byte register into the sequence state or the result register,
// which drives output valid; the sequence state update loops on itself.
// Synchronous active-low reset empties both registers and closes any sequence.
// A stalled output holds its result; the byte register still takes one more
// byte, and input ready drops only when both stages are full.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    u8dec_byte_if.sink        i_byte,
    u8dec_char_if.source      o_char
);

    logic                          r_in_valid;
    logic [u8dec_pkg::BYTE_W-1:0]  r_in_byte;

    logic [u8dec_pkg::PEND_W-1:0]  r_pending, n_pending;
    logic [u8dec_pkg::CP_W-1:0]    r_partial, n_partial;
    logic [u8dec_pkg::LEN_W-1:0]   r_seq_len, n_seq_len;

    logic                          r_out_valid;
    logic [u8dec_pkg::CP_W-1:0]    r_cp, n_cp;
    logic [u8dec_pkg::LEN_W-1:0]   r_len, n_len;
    u8dec_pkg::t_status            r_st, n_st;
    logic                          n_emit;

    logic                          advance;
    logic [u8dec_pkg::CP_W-1:0]    shifted;

    assign advance      = !r_out_valid || o_char.ready;
    assign i_byte.ready = !r_in_valid || advance;

    assign shifted = {r_partial[u8dec_pkg::CP_W-7:0],
                      r_in_byte[5:0] & u8dec_pkg::CONT_MASK[5:0]};

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_seq_len = r_seq_len;
        n_emit    = 1'b0;
        n_cp      = '0;
        n_len     = u8dec_pkg::LEN_NONE;
        n_st      = u8dec_pkg::ST_OK;
        if (r_pending == '0) begin
            unique case (r_in_byte) inside
                8'b0???????: begin
                    n_emit = 1'b1;
                    n_cp   = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, r_in_byte};
                    n_len  = u8dec_pkg::LEN_ONE;
                end
                8'b110?????: begin
                    n_partial = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}},
                                 r_in_byte & u8dec_pkg::LEAD2_MASK};
                    n_pending = 2'd1;
                    n_seq_len = u8dec_pkg::LEN_TWO;
                end
                8'b1110????: begin
                    n_partial = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}},
                                 r_in_byte & u8dec_pkg::LEAD3_MASK};
                    n_pending = 2'd2;
                    n_seq_len = u8dec_pkg::LEN_THR;
                end
                8'b11110???: begin
                    n_partial = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}},
                                 r_in_byte & u8dec_pkg::LEAD4_MASK};
                    n_pending = 2'd3;
                    n_seq_len = u8dec_pkg::LEN_FOUR;
                end
                default: begin
                    n_emit    = 1'b1;
                    n_st      = u8dec_pkg::ST_BAD_LEAD;
                    n_pending = '0;
                    n_partial = '0;
                    n_seq_len = u8dec_pkg::LEN_NONE;
                end
            endcase
        end else if (r_in_byte[7:6] != 2'b10) begin
            n_emit    = 1'b1;
            n_st      = u8dec_pkg::ST_NO_CONT;
            n_pending = '0;
            n_partial = '0;
            n_seq_len = u8dec_pkg::LEN_NONE;
        end else if (r_pending == 2'd1) begin
            n_emit    = 1'b1;
            n_cp      = shifted;
            n_len     = r_seq_len;
            n_pending = '0;
            n_partial = '0;
            n_seq_len = u8dec_pkg::LEN_NONE;
        end else begin
            n_partial = shifted;
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_partial   <= '0;
            r_seq_len   <= u8dec_pkg::LEN_NONE;
        end else begin
            if (i_byte.valid && i_byte.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && n_emit;
                if (r_in_valid) begin
                    r_pending <= n_pending;
                    r_partial <= n_partial;
                    r_seq_len <= n_seq_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.in_byte;
        end
        if (advance && r_in_valid && n_emit) begin
            r_cp  <= n_cp;
            r_len <= n_len;
            r_st  <= n_st;
        end
    end

    assign o_char.valid      = r_out_valid;
    assign o_char.code_point = r_cp;
    assign o_char.seq_bytes  = r_len;
    assign o_char.status     = r_st;

    // closed sequence leaves no residue
    a_closed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == '0) |-> (r_partial == '0 && r_seq_len == u8dec_pkg::LEN_NONE))
        else $error("sequence state not cleared");

    // open sequence length exceeds pending count and is at most four
    a_open_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) |-> ({1'b0, r_pending} < r_seq_len
                               && r_seq_len <= u8dec_pkg::LEN_FOUR))
        else $error("pending count and sequence length disagree");

    // error results carry no character
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_st != u8dec_pkg::ST_OK) |-> (r_cp == '0
                                                      && r_len == u8dec_pkg::LEN_NONE))
        else $error("error result carries data");

    // good results have a real length; single-byte ones are ASCII
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_st == u8dec_pkg::ST_OK) |-> (r_len != u8dec_pkg::LEN_NONE
            && (r_len != u8dec_pkg::LEN_ONE || r_cp[u8dec_pkg::CP_W-1:7] == '0)))
        else $error("bad length on good result");

    // a transfer into a full byte register only when it drains the same cycle
    a_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && r_in_valid) |-> advance)
        else $error("byte register overwritten");

endmodule

`default_nettype wire
